/* rtl/fibonacci_delta_audio_packer_defines.svh */
// Assertion helpers, clocked on clk_i and held off while rst_ni is low.
`ifndef FIBONACCI_DELTA_AUDIO_PACKER_DEFINES_SVH
`define FIBONACCI_DELTA_AUDIO_PACKER_DEFINES_SVH

`define FDAP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

`define FDAP_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`endif

/* rtl/fdap_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package fdap_pkg;

  localparam int unsigned QDepth = 2;
  localparam int unsigned QPtrW  = $clog2(QDepth);

  localparam logic signed [7:0] FIB_DELTA [16] = '{
    -8'sd34, -8'sd21, -8'sd13, -8'sd8, -8'sd5, -8'sd3, -8'sd2, -8'sd1,
    8'sd0, 8'sd1, 8'sd2, 8'sd3, 8'sd5, 8'sd8, 8'sd13, 8'sd21
  };

  localparam logic signed [9:0] CLAMP_MAX = 10'sd127;
  localparam logic signed [9:0] CLAMP_MIN = -10'sd128;

  typedef enum logic {
    MODE_SAMPLE = 1'b0,
    MODE_FINISH = 1'b1
  } mode_e;

  // one queued request: one or two result beats
  typedef struct packed {
    logic        two;
    logic        valid;
    logic [7:0]  b0;
    logic [7:0]  b1;
    logic [31:0] st;
    logic [31:0] bt;
  } op_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage
`default_nettype wire

/* rtl/fdap_front.sv */
`timescale 1ns / 1ps
`default_nettype none
module fdap_front (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            cfg_valid_i,
  input  wire logic            cfg_data_i,
  input  wire logic            s_tvalid_i,
  output logic                 s_tready_o,
  input  wire logic [15:0]     s_tdata_i,
  input  wire logic            s_tuser_i,
  input  wire fdap_pkg::q_stat_t q_stat_i,
  output logic                 push_o,
  output fdap_pkg::op_t        op_o
);
  import fdap_pkg::*;

  logic              en_q;
  logic              started_q, started_d;
  logic signed [7:0] pred_q, pred_d;
  logic              half_q, half_d;
  logic [3:0]        held_q, held_d;
  logic [31:0]       bcnt_q, bcnt_d;
  logic [31:0]       scnt_q, scnt_d;

  logic              fire;
  logic signed [7:0] s8;
  logic signed [7:0] base;
  logic signed [7:0] cand [16];
  logic [7:0]        err  [16];
  logic [3:0]        idx1 [8];
  logic [7:0]        err1 [8];
  logic [3:0]        idx2 [4];
  logic [7:0]        err2 [4];
  logic [3:0]        idx3 [2];
  logic [7:0]        err3 [2];
  logic [3:0]        nib;
  logic [31:0]       bcnt_p1, bcnt_p2;

  assign s_tready_o = !q_stat_i.full;
  assign fire       = s_tvalid_i && s_tready_o;
  assign s8         = s_tdata_i[15:8];
  assign base       = started_q ? pred_q : s8;
  assign bcnt_p1    = bcnt_q + 32'd1;
  assign bcnt_p2    = bcnt_q + 32'd2;

  // 16 clamped candidates and their errors, in parallel
  always_comb begin
    logic signed [9:0] sum;
    logic signed [8:0] diff;
    for (int i = 0; i < 16; i++) begin
      sum = 10'(base) + 10'(FIB_DELTA[i]);
      if (sum > CLAMP_MAX) begin
        cand[i] = CLAMP_MAX[7:0];
      end else if (sum < CLAMP_MIN) begin
        cand[i] = CLAMP_MIN[7:0];
      end else begin
        cand[i] = sum[7:0];
      end
      diff = 9'(cand[i]) - 9'(s8);
      err[i] = diff[8] ? 8'(-diff) : diff[7:0];
    end
  end

  // least-error tree, lower index wins ties
  always_comb begin
    for (int j = 0; j < 8; j++) begin
      if (err[2*j+1] < err[2*j]) begin
        idx1[j] = 4'(2*j+1);
        err1[j] = err[2*j+1];
      end else begin
        idx1[j] = 4'(2*j);
        err1[j] = err[2*j];
      end
    end
    for (int j = 0; j < 4; j++) begin
      if (err1[2*j+1] < err1[2*j]) begin
        idx2[j] = idx1[2*j+1];
        err2[j] = err1[2*j+1];
      end else begin
        idx2[j] = idx1[2*j];
        err2[j] = err1[2*j];
      end
    end
    for (int j = 0; j < 2; j++) begin
      if (err2[2*j+1] < err2[2*j]) begin
        idx3[j] = idx2[2*j+1];
        err3[j] = err2[2*j+1];
      end else begin
        idx3[j] = idx2[2*j];
        err3[j] = err2[2*j];
      end
    end
    nib = (err3[1] < err3[0]) ? idx3[1] : idx3[0];
  end

  always_comb begin
    started_d = started_q;
    pred_d    = pred_q;
    half_d    = half_q;
    held_d    = held_q;
    bcnt_d    = bcnt_q;
    scnt_d    = scnt_q;
    push_o    = 1'b0;
    op_o      = '0;
    if (fire) begin
      case (mode_e'(s_tuser_i))
        MODE_SAMPLE: begin
          scnt_d = scnt_q + 32'd1;
          if (en_q) begin
            started_d = 1'b1;
            pred_d    = cand[nib];
            half_d    = !half_q;
            held_d    = nib;
            if (!started_q) begin
              push_o   = 1'b1;
              op_o.two = 1'b1;
              op_o.valid = 1'b1;
              op_o.b1  = s8;
              bcnt_d   = bcnt_p2;
            end else if (half_q) begin
              push_o     = 1'b1;
              op_o.valid = 1'b1;
              op_o.b0    = {held_q, nib};
              bcnt_d     = bcnt_p1;
            end
          end else begin
            push_o     = 1'b1;
            op_o.valid = 1'b1;
            op_o.b0    = s8;
            bcnt_d     = bcnt_p1;
          end
        end
        MODE_FINISH: begin
          push_o  = 1'b1;
          op_o.st = scnt_q;
          if (en_q && !started_q) begin
            op_o.two   = 1'b1;
            op_o.valid = 1'b1;
            op_o.bt    = bcnt_p2;
          end else if (en_q && half_q) begin
            op_o.valid = 1'b1;
            op_o.b0    = {held_q, 4'h0};
            op_o.two   = bcnt_p1[0];
            op_o.bt    = bcnt_p1;
          end else begin
            op_o.valid = bcnt_q[0];
            op_o.bt    = bcnt_q;
          end
          started_d = 1'b0;
          pred_d    = '0;
          half_d    = 1'b0;
          held_d    = '0;
          bcnt_d    = '0;
          scnt_d    = '0;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      en_q      <= 1'b0;
      started_q <= 1'b0;
      pred_q    <= '0;
      half_q    <= 1'b0;
      held_q    <= '0;
      bcnt_q    <= '0;
      scnt_q    <= '0;
    end else begin
      if (cfg_valid_i) begin
        en_q <= cfg_data_i;
      end
      started_q <= started_d;
      pred_q    <= pred_d;
      half_q    <= half_d;
      held_q    <= held_d;
      bcnt_q    <= bcnt_d;
      scnt_q    <= scnt_d;
    end
  end

endmodule
`default_nettype wire

/* rtl/fdap_queue.sv */
`timescale 1ns / 1ps
`default_nettype none
module fdap_queue (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push_i,
  input  wire fdap_pkg::op_t op_i,
  input  wire logic          pop_i,
  output fdap_pkg::op_t      op_o,
  output fdap_pkg::q_stat_t  stat_o
);
  import fdap_pkg::*;

  op_t              slot_q [QDepth];
  logic [QPtrW-1:0] wr_q, rd_q;
  logic [QPtrW:0]   cnt_q, cnt_d;

  assign op_o         = slot_q[rd_q];
  assign stat_o.full  = (cnt_q == (QPtrW+1)'(QDepth));
  assign stat_o.empty = (cnt_q == '0);

  always_comb begin
    cnt_d = cnt_q;
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + (QPtrW+1)'(1);
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - (QPtrW+1)'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_q] <= op_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= wr_q + QPtrW'(1);
      end
      if (pop_i) begin
        rd_q <= rd_q + QPtrW'(1);
      end
      cnt_q <= cnt_d;
    end
  end

endmodule
`default_nettype wire

/* rtl/fdap_back.sv */
`timescale 1ns / 1ps
`default_nettype none
`include "fibonacci_delta_audio_packer_defines.svh"
module fdap_back (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire fdap_pkg::op_t     op_i,
  input  wire fdap_pkg::q_stat_t q_stat_i,
  output logic                   pop_o,
  output logic                   m_tvalid_o,
  input  wire logic              m_tready_i,
  output logic [71:0]            m_tdata_o,
  output logic                   m_tuser_o,
  output logic                   m_tlast_o
);
  import fdap_pkg::*;

  logic        vld_q, vld_d;
  logic [71:0] data_q, data_d;
  logic        user_q, user_d;
  logic        last_q, last_d;
  logic        pend_q, pend_d;
  logic [7:0]  b1_q, b1_d;
  logic [31:0] st_q, st_d;
  logic [31:0] bt_q, bt_d;
  logic        load;

  assign load  = !vld_q || m_tready_i;
  assign pop_o = load && !pend_q && !q_stat_i.empty;

  always_comb begin
    vld_d  = vld_q;
    data_d = data_q;
    user_d = user_q;
    last_d = last_q;
    pend_d = pend_q;
    b1_d   = b1_q;
    st_d   = st_q;
    bt_d   = bt_q;
    if (load) begin
      if (pend_q) begin
        vld_d  = 1'b1;
        data_d = {bt_q, st_q, b1_q};
        user_d = 1'b1;
        last_d = 1'b1;
        pend_d = 1'b0;
      end else if (!q_stat_i.empty) begin
        vld_d  = 1'b1;
        data_d = {op_i.bt, op_i.st, op_i.b0};
        user_d = op_i.valid;
        last_d = !op_i.two;
        pend_d = op_i.two;
        b1_d   = op_i.b1;
        st_d   = op_i.st;
        bt_d   = op_i.bt;
      end else begin
        vld_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= 1'b0;
      pend_q <= 1'b0;
    end else begin
      vld_q  <= vld_d;
      pend_q <= pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
    user_q <= user_d;
    last_q <= last_d;
    b1_q   <= b1_d;
    st_q   <= st_d;
    bt_q   <= bt_d;
  end

  assign m_tvalid_o = vld_q;
  assign m_tdata_o  = data_q;
  assign m_tuser_o  = user_q;
  assign m_tlast_o  = last_q;

  `FDAP_ASSERT(a_pend_on_beat, !pend_q || (vld_q && !last_q), "second beat pending off a first beat")
  `FDAP_ASSERT(a_no_pop_pend, !(pend_q && pop_o), "queue popped while second beat pending")
  `FDAP_ASSERT_NEXT(a_pop_loads, pop_o, vld_q, "popped request not presented")

endmodule
`default_nettype wire

/* rtl/fibonacci_delta_audio_packer.sv */
// A request's first result goes through the request queue, then the output register.
// Throughput: one input per cycle unless the queue is full; one result out per cycle
// while m_tready_i is high, so a two-result request holds the back end until both go.
// A two-entry request queue sits between front and back end.
// Reset (rst_ni low, asynchronous) clears all stream state and compress_enable.
`timescale 1ns / 1ps
`default_nettype none
module fibonacci_delta_audio_packer (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic        cfg_data_i,    // compress_enable
  input  wire logic        s_tvalid_i,
  output logic             s_tready_o,
  input  wire logic [15:0] s_tdata_i,     // [15:0] sample
  input  wire logic        s_tuser_i,     // [0] mode
  output logic             m_tvalid_o,
  input  wire logic        m_tready_i,
  output logic [71:0]      m_tdata_o,     // [7:0] out_byte, [39:8] samples_total,
                                          // [71:40] body_total
  output logic             m_tuser_o,     // [0] byte_valid
  output logic             m_tlast_o
);
  import fdap_pkg::*;

  op_t     push_op, head_op;
  logic    push, pop;
  q_stat_t q_stat;

  assign cfg_ready_o = 1'b1;

  fdap_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_data_i  (cfg_data_i),
    .s_tvalid_i  (s_tvalid_i),
    .s_tready_o  (s_tready_o),
    .s_tdata_i   (s_tdata_i),
    .s_tuser_i   (s_tuser_i),
    .q_stat_i    (q_stat),
    .push_o      (push),
    .op_o        (push_op)
  );

  fdap_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .op_i   (push_op),
    .pop_i  (pop),
    .op_o   (head_op),
    .stat_o (q_stat)
  );

  fdap_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .op_i       (head_op),
    .q_stat_i   (q_stat),
    .pop_o      (pop),
    .m_tvalid_o (m_tvalid_o),
    .m_tready_i (m_tready_i),
    .m_tdata_o  (m_tdata_o),
    .m_tuser_o  (m_tuser_o),
    .m_tlast_o  (m_tlast_o)
  );

endmodule
`default_nettype wire
